>>> design/ihf_pkg.sv
// Shared types and constants for the IPv4 TCP/UDP header filter.
`default_nettype none
package ihf_pkg;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [3:0]  IHL_MASK   = 4'hF;

  localparam int          OFFSET_W   = 7;
  localparam logic [6:0]  OFFSET_MAX = 7'd127;

  // Fixed header offsets (byte positions in the frame)
  localparam logic [6:0]  OFF_ETYPE_HI = 7'd12;
  localparam logic [6:0]  OFF_ETYPE_LO = 7'd13;
  localparam logic [6:0]  OFF_IHL      = 7'd14;
  localparam logic [6:0]  OFF_LEN_HI   = 7'd16;
  localparam logic [6:0]  OFF_LEN_LO   = 7'd17;
  localparam logic [6:0]  OFF_TTL      = 7'd22;
  localparam logic [6:0]  OFF_PROTO    = 7'd23;
  localparam logic [6:0]  OFF_SRC_LO   = 7'd26;
  localparam logic [6:0]  OFF_SRC_HI   = 7'd29;
  localparam logic [6:0]  OFF_DST_LO   = 7'd30;
  localparam logic [6:0]  OFF_DST_HI   = 7'd33;

  localparam logic [7:0]  ETH_HDR_LEN  = 8'd14;
  localparam logic [7:0]  MIN_IP_LEN   = 8'd34;

  // Verdict codes
  localparam logic [2:0]  VERDICT_PASS      = 3'd0;
  localparam logic [2:0]  VERDICT_NOT_IP    = 3'd1;
  localparam logic [2:0]  VERDICT_NOT_L4    = 3'd2;
  localparam logic [2:0]  VERDICT_FILTERED  = 3'd3;
  localparam logic [2:0]  VERDICT_TRUNCATED = 3'd4;

  // Configuration register indexes
  localparam int          CFG_INDEX_W      = 2;
  localparam logic [1:0]  CFG_SRC_IP       = 2'd0;
  localparam logic [1:0]  CFG_DST_IP       = 2'd1;
  localparam logic [1:0]  CFG_SRC_PORT     = 2'd2;
  localparam logic [1:0]  CFG_DST_PORT     = 2'd3;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  ttl;
    logic [15:0] total_length;
  } out_item_t;

endpackage
`default_nettype wire

>>> design/ip_tcp_udp_header_filter.sv
// Byte-serial Ethernet/IPv4/TCP-UDP header capture and five-field filter.
// Throughput: one frame byte per cycle while not stalled, independent of frame content.
// On the last byte the verdict goes into the output register or the skid register.
// A two-entry output (output register plus skid register) keeps the input stall registered.
// Reset (rst, synchronous, active high) clears the filter registers to "match any",
// the capture registers and the byte offset, and empties the output stage.
`default_nettype none
module ip_tcp_udp_header_filter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // frame byte stream
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire ihf_pkg::in_item_t              in_data,
  // verdict stream
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      ihf_pkg::out_item_t             out_data,
  // configuration writes
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [ihf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import ihf_pkg::*;

  // filter registers, zero means "any"
  logic [31:0] match_src_ip;
  logic [31:0] match_dst_ip;
  logic [15:0] match_src_port;
  logic [15:0] match_dst_port;

  // capture state
  logic [OFFSET_W-1:0] byte_offset;
  logic [15:0]         ether_type;
  logic [3:0]          header_words;
  logic [7:0]          proto_reg;
  logic [7:0]          ttl_reg;
  logic [15:0]         length_reg;
  logic [31:0]         src_addr_reg;
  logic [31:0]         dst_addr_reg;
  logic [15:0]         src_port_reg;
  logic [15:0]         dst_port_reg;

  logic [15:0] ether_type_next;
  logic [3:0]  header_words_next;
  logic [7:0]  proto_next;
  logic [7:0]  ttl_next;
  logic [15:0] length_next;
  logic [31:0] src_addr_next;
  logic [31:0] dst_addr_next;
  logic [15:0] src_port_next;
  logic [15:0] dst_port_next;

  // transport header start and frame-length checks
  logic [7:0] l4_start;
  logic [7:0] off_w;
  logic [7:0] byte_count;
  logic [7:0] need_len;
  logic [2:0] verdict;
  logic       filter_miss;

  // output stage: main register plus skid register
  logic       skid_valid;
  out_item_t  skid_data;
  out_item_t  result;
  logic       in_xfer;
  logic       result_valid;
  logic       out_xfer;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_xfer   = in_valid && !in_stall;
  assign result_valid = in_xfer && in_data.frame_last;
  assign out_xfer  = out_valid && !out_stall;

  // ---------------------------------------------------------------------------
  // Field capture. Each capture is a shift-in of the current byte when the
  // offset falls in the field's window. IHL is taken the same cycle it is
  // used, so with IHL of zero the IHL byte also lands in the source port.
  // ---------------------------------------------------------------------------
  always_comb begin
    off_w = {1'b0, byte_offset};

    ether_type_next = ether_type;
    if (byte_offset == OFF_ETYPE_HI || byte_offset == OFF_ETYPE_LO) begin
      ether_type_next = {ether_type[7:0], in_data.frame_byte};
    end

    header_words_next = header_words;
    if (byte_offset == OFF_IHL) begin
      header_words_next = in_data.frame_byte[3:0] & IHL_MASK;
    end

    length_next = length_reg;
    if (byte_offset == OFF_LEN_HI || byte_offset == OFF_LEN_LO) begin
      length_next = {length_reg[7:0], in_data.frame_byte};
    end

    ttl_next = ttl_reg;
    if (byte_offset == OFF_TTL) begin
      ttl_next = in_data.frame_byte;
    end

    proto_next = proto_reg;
    if (byte_offset == OFF_PROTO) begin
      proto_next = in_data.frame_byte;
    end

    src_addr_next = src_addr_reg;
    if (byte_offset >= OFF_SRC_LO && byte_offset <= OFF_SRC_HI) begin
      src_addr_next = {src_addr_reg[23:0], in_data.frame_byte};
    end

    dst_addr_next = dst_addr_reg;
    if (byte_offset >= OFF_DST_LO && byte_offset <= OFF_DST_HI) begin
      dst_addr_next = {dst_addr_reg[23:0], in_data.frame_byte};
    end

    // transport header starts at 14 + 4*IHL, at most 74
    l4_start = ETH_HDR_LEN + {2'b00, header_words_next, 2'b00};

    src_port_next = src_port_reg;
    if (off_w >= l4_start && off_w < l4_start + 8'd2) begin
      src_port_next = {src_port_reg[7:0], in_data.frame_byte};
    end

    dst_port_next = dst_port_reg;
    if (off_w >= l4_start + 8'd2 && off_w < l4_start + 8'd4) begin
      dst_port_next = {dst_port_reg[7:0], in_data.frame_byte};
    end
  end

  // ---------------------------------------------------------------------------
  // Verdict on the last byte, from the values including that byte.
  // ---------------------------------------------------------------------------
  always_comb begin
    byte_count = off_w + 8'd1;
    need_len   = (l4_start + 8'd4 > MIN_IP_LEN) ? (l4_start + 8'd4) : MIN_IP_LEN;

    filter_miss = (match_src_ip   != '0 && src_addr_next != match_src_ip)   ||
                  (match_dst_ip   != '0 && dst_addr_next != match_dst_ip)   ||
                  (match_src_port != '0 && src_port_next != match_src_port) ||
                  (match_dst_port != '0 && dst_port_next != match_dst_port);

    if (byte_count < ETH_HDR_LEN) begin
      verdict = VERDICT_TRUNCATED;
    end else if (ether_type_next != ETYPE_IPV4) begin
      verdict = VERDICT_NOT_IP;
    end else if (byte_count < MIN_IP_LEN) begin
      verdict = VERDICT_TRUNCATED;
    end else if (proto_next != PROTO_TCP && proto_next != PROTO_UDP) begin
      verdict = VERDICT_NOT_L4;
    end else if (byte_count < need_len) begin
      verdict = VERDICT_TRUNCATED;
    end else if (filter_miss) begin
      verdict = VERDICT_FILTERED;
    end else begin
      verdict = VERDICT_PASS;
    end

    result.verdict      = verdict;
    result.protocol     = proto_next;
    result.src_addr     = src_addr_next;
    result.dst_addr     = dst_addr_next;
    result.src_port     = src_port_next;
    result.dst_port     = dst_port_next;
    result.ttl          = ttl_next;
    result.total_length = length_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      match_src_ip   <= '0;
      match_dst_ip   <= '0;
      match_src_port <= '0;
      match_dst_port <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SRC_IP:   match_src_ip   <= cfg_data;
        CFG_DST_IP:   match_dst_ip   <= cfg_data;
        CFG_SRC_PORT: match_src_port <= cfg_data[15:0];
        CFG_DST_PORT: match_dst_port <= cfg_data[15:0];
      endcase
    end
  end

  // capture registers; the last byte clears everything for the next frame
  always_ff @(posedge clk) begin
    if (rst || (in_xfer && in_data.frame_last)) begin
      byte_offset  <= '0;
      ether_type   <= '0;
      header_words <= '0;
      proto_reg    <= '0;
      ttl_reg      <= '0;
      length_reg   <= '0;
      src_addr_reg <= '0;
      dst_addr_reg <= '0;
      src_port_reg <= '0;
      dst_port_reg <= '0;
    end else if (in_xfer) begin
      if (byte_offset != OFFSET_MAX) begin
        byte_offset <= byte_offset + 7'd1;
      end
      ether_type   <= ether_type_next;
      header_words <= header_words_next;
      proto_reg    <= proto_next;
      ttl_reg      <= ttl_next;
      length_reg   <= length_next;
      src_addr_reg <= src_addr_next;
      dst_addr_reg <= dst_addr_next;
      src_port_reg <= src_port_next;
      dst_port_reg <= dst_port_next;
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // input is stalled; drain the skid entry when the output moves
      if (out_xfer) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (result_valid) begin
      if (!out_valid || !out_stall) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> test/filter_model_pkg.sv
`timescale 1ns / 100ps
// Verdict predictor and scoreboard for the header filter testbench.
package filter_model_pkg;
  import ihf_pkg::*;

  class frame_verdict_model;
    // filter registers as last written
    logic [31:0] src_ip_filter;
    logic [31:0] dst_ip_filter;
    logic [15:0] src_port_filter;
    logic [15:0] dst_port_filter;
    // per-frame capture state
    logic [6:0]  offset;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [7:0]  ttl;
    logic [15:0] len;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
    out_item_t   due_verdicts[$];
    int          mismatches;

    function new();
      src_ip_filter   = '0;
      dst_ip_filter   = '0;
      src_port_filter = '0;
      dst_port_filter = '0;
      mismatches      = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      offset = '0;
      etype  = '0;
      ihl    = '0;
      proto  = '0;
      ttl    = '0;
      len    = '0;
      saddr  = '0;
      daddr  = '0;
      sport  = '0;
      dport  = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_SRC_IP:   src_ip_filter   = val;
        CFG_DST_IP:   dst_ip_filter   = val;
        CFG_SRC_PORT: src_port_filter = val[15:0];
        CFG_DST_PORT: dst_port_filter = val[15:0];
        default: ;
      endcase
    endfunction

    // One frame byte transfer; a verdict is queued on the last byte.
    function void note_byte(in_item_t item);
      logic [7:0]  b;
      logic [2:0]  v;
      int unsigned off;
      int unsigned port_at;
      int unsigned count;
      int unsigned need;
      out_item_t   exp_v;
      b   = item.frame_byte;
      off = offset;
      if (off == OFF_ETYPE_HI || off == OFF_ETYPE_LO) etype = {etype[7:0], b};
      if (off == OFF_IHL) ihl = b[3:0] & IHL_MASK;
      if (off == OFF_LEN_HI || off == OFF_LEN_LO) len = {len[7:0], b};
      if (off == OFF_TTL) ttl = b;
      if (off == OFF_PROTO) proto = b;
      if (off >= OFF_SRC_LO && off <= OFF_SRC_HI) saddr = {saddr[23:0], b};
      if (off >= OFF_DST_LO && off <= OFF_DST_HI) daddr = {daddr[23:0], b};
      // port window uses the IHL as it stands after this byte
      port_at = ETH_HDR_LEN + 4 * ihl;
      if (off >= port_at && off < port_at + 2) sport = {sport[7:0], b};
      if (off >= port_at + 2 && off < port_at + 4) dport = {dport[7:0], b};
      if (!item.frame_last) begin
        if (offset != OFFSET_MAX) offset = offset + 7'd1;
        return;
      end
      count = off + 1;
      need  = (port_at + 4 > MIN_IP_LEN) ? port_at + 4 : MIN_IP_LEN;
      if (count < ETH_HDR_LEN) begin
        v = VERDICT_TRUNCATED;
      end else if (etype != ETYPE_IPV4) begin
        v = VERDICT_NOT_IP;
      end else if (count < MIN_IP_LEN) begin
        v = VERDICT_TRUNCATED;
      end else if (proto != PROTO_TCP && proto != PROTO_UDP) begin
        v = VERDICT_NOT_L4;
      end else if (count < need) begin
        v = VERDICT_TRUNCATED;
      end else if ((src_ip_filter != 0 && saddr != src_ip_filter) ||
                   (dst_ip_filter != 0 && daddr != dst_ip_filter) ||
                   (src_port_filter != 0 && sport != src_port_filter) ||
                   (dst_port_filter != 0 && dport != dst_port_filter)) begin
        v = VERDICT_FILTERED;
      end else begin
        v = VERDICT_PASS;
      end
      exp_v.verdict      = v;
      exp_v.protocol     = proto;
      exp_v.src_addr     = saddr;
      exp_v.dst_addr     = daddr;
      exp_v.src_port     = sport;
      exp_v.dst_port     = dport;
      exp_v.ttl          = ttl;
      exp_v.total_length = len;
      due_verdicts.push_back(exp_v);
      clear_frame();
    endfunction

    function void show(string tag, out_item_t r);
      $display("  %s v=%0d proto=%02h src=%08h dst=%08h sport=%04h dport=%04h ttl=%02h len=%04h",
               tag, r.verdict, r.protocol, r.src_addr, r.dst_addr, r.src_port, r.dst_port,
               r.ttl, r.total_length);
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t want;
      bit        bad;
      if (due_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: verdict transfer with nothing pending", $time);
          show("actual  ", got);
        end
        return;
      end
      want = due_verdicts.pop_front();
      bad = (got.verdict !== want.verdict) || (got.protocol !== want.protocol) ||
            (got.src_addr !== want.src_addr) || (got.dst_addr !== want.dst_addr) ||
            (got.src_port !== want.src_port) || (got.dst_port !== want.dst_port) ||
            (got.ttl !== want.ttl) || (got.total_length !== want.total_length);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: verdict mismatch", $time);
          show("expected", want);
          show("actual  ", got);
        end
      end
    endfunction

    function int leftover_check();
      if (due_verdicts.size() != 0) begin
        $display("%0d verdicts never arrived", due_verdicts.size());
        mismatches += due_verdicts.size();
      end
      return mismatches;
    endfunction
  endclass

endpackage

>>> test/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench for the Ethernet/IPv4 TCP/UDP header filter.
module testbench;
  import ihf_pkg::*;
  import filter_model_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 8;     // settling margin after the last verdict transfers
  localparam int SEGMENT_BYTES  = 190;
  localparam int SEGMENT_FRAMES = 4;
  localparam int MAX_FRAME      = 140;   // past the 127 offset saturation point

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0]            cfg_data = '0;

  frame_verdict_model model;
  logic [7:0]         frame_buf[$];
  int                 send_idle_pct = 14;
  int                 recv_idle_pct = 50;
  int                 hold_asks = 0;     // bumped by stimulus, served by the receiver
  int                 stuck_cycles = 0;

  ip_tcp_udp_header_filter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor: every transfer is seen here, on pre-edge values, so the model
  // never depends on process ordering. Also the no-progress watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) model.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) model.note_byte(in_data);
      if (out_valid && !out_stall) model.check_verdict(out_data);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Verdict receiver: random stall at the current rate, plus one long
  // hold-off per request so the output stage fills and in_stall rises.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // One byte transfer. Valid stays high across back-to-back bytes; a gap
  // drops it for whole cycles only, so each step sees one assignment.
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t item;
    item.frame_byte = b;
    item.frame_last = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  // Let every pending verdict come back, then give the output stage a
  // settling margin before the filters change.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (model.due_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_filters(input logic [31:0] sip, input logic [31:0] dip,
                                 input logic [15:0] sp, input logic [15:0] dp);
    put_reg(CFG_SRC_IP, sip);
    put_reg(CFG_DST_IP, dip);
    put_reg(CFG_SRC_PORT, {16'h0, sp});
    put_reg(CFG_DST_PORT, {16'h0, dp});
    cfg_valid <= 1'b0;
  endtask

  // Builds one frame into frame_buf. Most are well-formed IPv4 TCP/UDP with
  // addresses and ports that often hit the active filters; the rest cover
  // foreign EtherTypes, other protocols, short IHL, long and cut frames, noise.
  task automatic build_frame();
    logic [7:0]  raw [0:MAX_FRAME-1];
    logic [31:0] sa;
    logic [31:0] da;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] etype;
    logic [7:0]  proto;
    int          pick;
    int          ihl;
    int          port_at;
    int          need;
    int          n;
    foreach (raw[i]) raw[i] = 8'($urandom);
    pick  = $urandom_range(99);
    ihl   = ($urandom_range(9) < 7) ? 5 : $urandom_range(6, 15);
    etype = ETYPE_IPV4;
    proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    if (pick < 13) begin
      // foreign EtherType
      etype = 16'($urandom);
      if (etype == ETYPE_IPV4) etype = ~etype;
      ihl = $urandom_range(15);
    end else if (pick < 20) begin
      // IPv4 but neither TCP nor UDP
      proto = 8'($urandom);
      if (proto == PROTO_TCP || proto == PROTO_UDP) proto = ~proto;
      ihl = $urandom_range(15);
    end else if (pick < 30) begin
      // IHL below the legal minimum: ports overlap the IPv4 header
      ihl = $urandom_range(4);
    end
    sa = (model.src_ip_filter != 0 && $urandom_range(3) != 0) ? model.src_ip_filter
                                                               : $urandom;
    da = (model.dst_ip_filter != 0 && $urandom_range(3) != 0) ? model.dst_ip_filter
                                                               : $urandom;
    sp = (model.src_port_filter != 0 && $urandom_range(3) != 0) ? model.src_port_filter
                                                                 : 16'($urandom);
    dp = (model.dst_port_filter != 0 && $urandom_range(3) != 0) ? model.dst_port_filter
                                                                 : 16'($urandom);
    port_at = ETH_HDR_LEN + 4 * ihl;
    need    = (port_at + 4 > MIN_IP_LEN) ? port_at + 4 : MIN_IP_LEN;
    if (pick >= 6) begin
      raw[OFF_ETYPE_HI] = etype[15:8];
      raw[OFF_ETYPE_LO] = etype[7:0];
      raw[OFF_IHL]      = {raw[OFF_IHL][7:4], 4'(ihl)};
      raw[OFF_PROTO]    = proto;
      for (int k = 0; k < 4; k++) begin
        raw[OFF_SRC_LO + k] = sa[31 - 8 * k -: 8];
        raw[OFF_DST_LO + k] = da[31 - 8 * k -: 8];
      end
      if (port_at >= MIN_IP_LEN) begin
        raw[port_at]     = sp[15:8];
        raw[port_at + 1] = sp[7:0];
        raw[port_at + 2] = dp[15:8];
        raw[port_at + 3] = dp[7:0];
      end
    end
    if (pick < 6)
      n = $urandom_range(1, 40);                  // noise
    else if (pick < 20)
      n = $urandom_range(1, need + 8);
    else if (pick < 30)
      n = $urandom_range(need - 2, need + 6);
    else if (pick < 36)
      n = $urandom_range(100, MAX_FRAME);         // may run past offset 127
    else if (pick < 48)
      n = $urandom_range(1, need - 1);            // cut short
    else
      n = need + $urandom_range(0, 6);
    frame_buf.delete();
    for (int i = 0; i < n; i++) frame_buf.push_back(raw[i]);
  endtask

  task automatic run_segment();
    int seg_bytes;
    int seg_frames;
    seg_bytes  = 0;
    seg_frames = 0;
    while (seg_bytes < SEGMENT_BYTES || seg_frames < SEGMENT_FRAMES) begin
      build_frame();
      seg_bytes += frame_buf.size();
      seg_frames++;
      send_frame();
    end
  endtask

  initial begin : stimulus
    int seg;
    model = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-byte frames at both byte extremes, then a minimal
    // all-ones header (EtherType 0xFFFF) and a short random frame.
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_frame();
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    send_frame();
    frame_buf.delete();
    repeat (14) frame_buf.push_back(8'hFF);
    send_frame();
    frame_buf.delete();
    repeat (6) frame_buf.push_back(8'($urandom));
    send_frame();

    // Random segments, filters reprogrammed between them while idle.
    for (seg = 0; seg < 6; seg++) begin
      wait_drained();
      if (seg < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 50;
      end else if (seg < 4) begin
        send_idle_pct = 50;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: program_filters('0, '0, '0, '0);
        1: program_filters('1, '1, '1, '1);
        2, 5: program_filters($urandom, $urandom, 16'($urandom), 16'($urandom));
        default: program_filters($urandom_range(1) ? $urandom : 32'h0,
                                 $urandom_range(1) ? $urandom : 32'h0,
                                 $urandom_range(1) ? 16'($urandom) : 16'h0,
                                 $urandom_range(1) ? 16'($urandom) : 16'h0);
      endcase
      run_segment();
    end

    // Back pressure: receiver holds off while short frames keep coming,
    // so the two-entry output stage fills and the input must stall.
    hold_asks++;
    repeat (40) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
      send_frame();
    end

    wait_drained();
    if (model.leftover_check() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ihf_pkg.sv
design/ip_tcp_udp_header_filter.sv
test/filter_model_pkg.sv
test/testbench.sv
